>>> hdl/gsrl_pkg.sv
// gsrl_pkg: shared types, constants and hydraulic pairing for the gimbal slew rate limiter
// no dependencies; imported by gimbal_slew_rate_limiter
`timescale 1ns / 1ps
`default_nettype none

package gsrl_pkg;

  localparam int NUM_ENGINES = 3;
  localparam int MAX_ENGINES = 3;

  localparam int ANGLE_W  = 13;
  localparam int PRESS_W  = 12;
  localparam int RATE_W   = 16;
  localparam int LIMIT_W  = 12;
  localparam int TIME_W   = 10;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W   = TIME_W + RATE_W;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [PRESS_W-1:0]        press_t;
  typedef logic [LIMIT_W-1:0]        limit_t;
  typedef logic [PROD_W-1:0]         prod_t;

  // opcodes
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_LIM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_LIM   = 2'd3;

  // reset values
  localparam logic [PRESS_W-1:0] PRESS_THR_RST = 12'd1500;
  localparam logic [RATE_W-1:0]  SLEW_RATE_RST = 16'd3840;
  localparam logic [LIMIT_W-1:0] PITCH_LIM_RST = 12'd2688;
  localparam logic [LIMIT_W-1:0] YAW_LIM_RST   = 12'd2176;

  // hydraulic system pairing per engine, entry 0 is the center engine
  localparam logic [MAX_ENGINES-1:0][1:0] PITCH_PRI = {2'd2, 2'd1, 2'd0};
  localparam logic [MAX_ENGINES-1:0][1:0] PITCH_SEC = {2'd1, 2'd0, 2'd2};
  localparam logic [MAX_ENGINES-1:0][1:0] YAW_PRI   = {2'd1, 2'd0, 2'd2};
  localparam logic [MAX_ENGINES-1:0][1:0] YAW_SEC   = {2'd2, 2'd1, 2'd0};

endpackage

`default_nettype wire

>>> hdl/gimbal_slew_rate_limiter.sv
// gimbal_slew_rate_limiter: six actuator slew rate limiter with position clamp
// depends on gsrl_pkg
// an input transaction passes through the input register and then the result register
// throughput: one transaction per cycle; a waiting result stalls the input once both registers are full
// the tick product is one 10x16 multiply shared by all six actuators in the single stage
// reset (synchronous, active low): positions and goals zero, config registers at defaults
`timescale 1ns / 1ps
`default_nettype none

module gimbal_slew_rate_limiter (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [15:0]               cfg_wdata,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_opcode,
  input  wire logic [1:0]                in_engine,
  input  wire gsrl_pkg::angle_t          in_pitch_target,
  input  wire gsrl_pkg::angle_t          in_yaw_target,
  input  wire gsrl_pkg::press_t          in_press_1,
  input  wire gsrl_pkg::press_t          in_press_2,
  input  wire gsrl_pkg::press_t          in_press_3,
  input  wire logic [9:0]                in_tick_time,
  // result channel
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output gsrl_pkg::angle_t               out_center_pitch,
  output gsrl_pkg::angle_t               out_center_yaw,
  output gsrl_pkg::angle_t               out_left_pitch,
  output gsrl_pkg::angle_t               out_left_yaw,
  output gsrl_pkg::angle_t               out_right_pitch,
  output gsrl_pkg::angle_t               out_right_yaw
);

  import gsrl_pkg::*;

  // configuration registers
  logic [PRESS_W-1:0] press_thr_r;
  logic [RATE_W-1:0]  slew_rate_r;
  limit_t             pitch_lim_r;
  limit_t             yaw_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_thr_r <= PRESS_THR_RST;
      slew_rate_r <= SLEW_RATE_RST;
      pitch_lim_r <= PITCH_LIM_RST;
      yaw_lim_r   <= YAW_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESS_THR: press_thr_r <= cfg_wdata[PRESS_W-1:0];
        REG_SLEW_RATE: slew_rate_r <= cfg_wdata[RATE_W-1:0];
        REG_PITCH_LIM: pitch_lim_r <= cfg_wdata[LIMIT_W-1:0];
        REG_YAW_LIM:   yaw_lim_r   <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               in_vld_r;
  logic               op_r;
  logic [1:0]         eng_r;
  angle_t             ptgt_r;
  angle_t             ytgt_r;
  press_t             p1_r;
  press_t             p2_r;
  press_t             p3_r;
  logic [TIME_W-1:0]  tick_r;
  logic               adv;

  assign adv      = in_vld_r && (!out_valid || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_opcode;
      eng_r  <= in_engine;
      ptgt_r <= in_pitch_target;
      ytgt_r <= in_yaw_target;
      p1_r   <= in_press_1;
      p2_r   <= in_press_2;
      p3_r   <= in_press_3;
      tick_r <= in_tick_time;
    end
  end

  // one actuator: jump to goal within a step, else one truncated step, then clamp; an unpowered actuator holds
  function automatic angle_t slew_one(angle_t cur, angle_t goal, logic pwr,
                                      prod_t prod, limit_t limit);
    logic signed [ANGLE_W:0]   diff;
    logic [ANGLE_W-1:0]        mag;
    logic                      jump;
    logic [RATE_W-1:0]         step;
    logic signed [RATE_W+1:0]  mv;
    logic signed [RATE_W+1:0]  lim;
    diff = (ANGLE_W+1)'(goal) - (ANGLE_W+1)'(cur);
    mag  = diff[ANGLE_W] ? ANGLE_W'(-diff) : ANGLE_W'(diff);
    jump = {{(PROD_W-ANGLE_W-10){1'b0}}, mag, 10'b0} < prod;
    step = prod[PROD_W-1:10];
    if (jump) begin
      mv = (RATE_W+2)'(goal);
    end else if (diff > 0) begin
      mv = (RATE_W+2)'(cur) + signed'({2'b00, step});
    end else if (diff < 0) begin
      mv = (RATE_W+2)'(cur) - signed'({2'b00, step});
    end else begin
      mv = (RATE_W+2)'(cur);
    end
    lim = signed'({{(RATE_W+2-LIMIT_W){1'b0}}, limit});
    if (mv > lim) mv = lim;
    if (mv < -lim) mv = -lim;
    return pwr ? ANGLE_W'(mv) : cur;
  endfunction

  // actuator state
  angle_t ppos_r [NUM_ENGINES];
  angle_t ypos_r [NUM_ENGINES];
  angle_t pgoal_r [NUM_ENGINES];
  angle_t ygoal_r [NUM_ENGINES];
  angle_t ppos_nxt [NUM_ENGINES];
  angle_t ypos_nxt [NUM_ENGINES];

  prod_t      prod;
  logic [2:0] ok;

  assign prod = PROD_W'(tick_r) * PROD_W'(slew_rate_r);
  assign ok   = {p3_r >= press_thr_r, p2_r >= press_thr_r, p1_r >= press_thr_r};

  for (genvar e = 0; e < NUM_ENGINES; e++) begin : g_eng
    logic ppwr;
    logic ypwr;
    assign ppwr = ok[PITCH_PRI[e]] | ok[PITCH_SEC[e]];
    assign ypwr = ok[YAW_PRI[e]] | ok[YAW_SEC[e]];

    always_comb begin
      ppos_nxt[e] = ppos_r[e];
      ypos_nxt[e] = ypos_r[e];
      if (op_r == OP_TICK) begin
        ppos_nxt[e] = slew_one(ppos_r[e], pgoal_r[e], ppwr, prod, pitch_lim_r);
        ypos_nxt[e] = slew_one(ypos_r[e], ygoal_r[e], ypwr, prod, yaw_lim_r);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ppos_r[e]  <= '0;
        ypos_r[e]  <= '0;
        pgoal_r[e] <= '0;
        ygoal_r[e] <= '0;
      end else if (adv) begin
        ppos_r[e] <= ppos_nxt[e];
        ypos_r[e] <= ypos_nxt[e];
        // engine index three never matches a built engine
        if (op_r == OP_CMD && eng_r == 2'(e)) begin
          pgoal_r[e] <= ptgt_r;
          ygoal_r[e] <= ytgt_r;
        end
      end
    end
  end

  // result register, unbuilt engines read zero
  angle_t res_p [MAX_ENGINES];
  angle_t res_y [MAX_ENGINES];
  logic   out_vld_r;
  angle_t outp_r [MAX_ENGINES];
  angle_t outy_r [MAX_ENGINES];

  for (genvar e = 0; e < MAX_ENGINES; e++) begin : g_res
    if (e < NUM_ENGINES) begin : g_built
      assign res_p[e] = ppos_nxt[e];
      assign res_y[e] = ypos_nxt[e];
    end else begin : g_none
      assign res_p[e] = '0;
      assign res_y[e] = '0;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        outp_r[e] <= res_p[e];
        outy_r[e] <= res_y[e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_center_pitch = outp_r[0];
  assign out_center_yaw   = outy_r[0];
  assign out_left_pitch   = outp_r[1];
  assign out_left_yaw     = outy_r[1];
  assign out_right_pitch  = outp_r[2];
  assign out_right_yaw    = outy_r[2];

  // a transaction leaving the input register always lands in the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("result register not loaded after advance");

  // a command never moves the center engine position
  a_cmd_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && op_r == OP_CMD) |=> ($stable(ppos_r[0]) && $stable(ypos_r[0])))
    else $error("position changed on a command transaction");

  // a tick never changes the center engine goal
  a_tick_keeps_goal: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && op_r == OP_TICK) |=> ($stable(pgoal_r[0]) && $stable(ygoal_r[0])))
    else $error("goal changed on a tick transaction");

  // a full input register only takes a new transaction while draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_vld_r) |-> adv)
    else $error("input register overwritten");

  // result drained with nothing behind it empties the result register
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ready && !adv) |=> !out_vld_r)
    else $error("result register did not empty");

endmodule

`default_nettype wire

>>> bench/gimbal_slew_rate_limiter_tb.sv
// gimbal_slew_rate_limiter_tb: self-checking bench for the six actuator gimbal slew limiter
// depends on gsrl_pkg and gimbal_slew_rate_limiter; directed items, then random phases
// over several register settings, each result checked against an in-bench predictor
`timescale 1ns / 1ps

module gimbal_slew_rate_limiter_tb;
  import gsrl_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 175;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_COUNT  = 9;

  localparam int unsigned THR_DEFAULT   = 1500;
  localparam int unsigned SLEW_DEFAULT  = 3840;
  localparam int unsigned PITCH_DEFAULT = 2688;
  localparam int unsigned YAW_DEFAULT   = 2176;

  // hydraulic systems feeding each actuator, entry 0 is the center engine
  localparam logic [2:0][1:0] PITCH_HYD_A = {2'd2, 2'd1, 2'd0};
  localparam logic [2:0][1:0] PITCH_HYD_B = {2'd1, 2'd0, 2'd2};
  localparam logic [2:0][1:0] YAW_HYD_A   = {2'd1, 2'd0, 2'd2};
  localparam logic [2:0][1:0] YAW_HYD_B   = {2'd2, 2'd1, 2'd0};

  typedef struct packed {
    logic        opcode;
    logic [1:0]  engine;
    angle_t      pitch_target;
    angle_t      yaw_target;
    press_t      press_1;
    press_t      press_2;
    press_t      press_3;
    logic [9:0]  tick_time;
  } gimbal_item_t;

  // index 0 center pitch, 1 center yaw, 2 left pitch, ... 5 right yaw
  typedef logic [5:0][ANGLE_W-1:0] gimbal_set_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PRESS_THR;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_opcode = OP_CMD;
  logic [1:0]           in_engine = '0;
  angle_t               in_pitch_target = '0;
  angle_t               in_yaw_target = '0;
  press_t               in_press_1 = '0;
  press_t               in_press_2 = '0;
  press_t               in_press_3 = '0;
  logic [9:0]           in_tick_time = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  angle_t               out_center_pitch;
  angle_t               out_center_yaw;
  angle_t               out_left_pitch;
  angle_t               out_left_yaw;
  angle_t               out_right_pitch;
  angle_t               out_right_yaw;

  gimbal_item_t pending_items[$];
  gimbal_set_t  expected_positions[$];
  int           outstanding = 0;
  int           mismatch_count = 0;
  int           in_idle_pct = 0;
  int           out_idle_pct = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  logic         in_took = 1'b0;
  int unsigned  cycle_count = 0;

  // predictor state and register shadows
  int unsigned thr_psi;
  int unsigned slew_per_s;
  int unsigned pitch_clamp;
  int unsigned yaw_clamp;
  angle_t      pitch_now [3];
  angle_t      yaw_now [3];
  angle_t      pitch_aim [3];
  angle_t      yaw_aim [3];

  gimbal_slew_rate_limiter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_engine        (in_engine),
    .in_pitch_target  (in_pitch_target),
    .in_yaw_target    (in_yaw_target),
    .in_press_1       (in_press_1),
    .in_press_2       (in_press_2),
    .in_press_3       (in_press_3),
    .in_tick_time     (in_tick_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_center_pitch (out_center_pitch),
    .out_center_yaw   (out_center_yaw),
    .out_left_pitch   (out_left_pitch),
    .out_left_yaw     (out_left_yaw),
    .out_right_pitch  (out_right_pitch),
    .out_right_yaw    (out_right_yaw)
  );

  always #5 clk = ~clk;

  function automatic string axis_name(int f);
    case (f)
      0: return "center_pitch";
      1: return "center_yaw";
      2: return "left_pitch";
      3: return "left_yaw";
      4: return "right_pitch";
      default: return "right_yaw";
    endcase
  endfunction

  function automatic angle_t slew_axis(angle_t pos, angle_t goal, bit powered,
                                       int unsigned prod, int unsigned limit);
    int cur;
    int diff;
    int mag;
    int lim;
    if (!powered) return pos;
    cur  = int'(pos);
    diff = int'(goal) - cur;
    mag  = (diff < 0) ? -diff : diff;
    lim  = int'(limit);
    // jump test is exact, the step itself is truncated
    if (longint'(mag) * 1024 < longint'(prod)) cur = int'(goal);
    else if (diff > 0) cur = cur + int'(prod >> 10);
    else if (diff < 0) cur = cur - int'(prod >> 10);
    if (cur > lim) cur = lim;
    if (cur < -lim) cur = -lim;
    return angle_t'(cur);
  endfunction

  function automatic gimbal_set_t advance_gimbals(gimbal_item_t it);
    gimbal_set_t res;
    logic [2:0]  sys_ok;
    int unsigned prod;
    bit          pitch_on;
    bit          yaw_on;
    if (it.opcode == OP_CMD) begin
      if (it.engine < NUM_ENGINES && it.engine < 3) begin
        pitch_aim[it.engine] = it.pitch_target;
        yaw_aim[it.engine]   = it.yaw_target;
      end
    end else begin
      prod = it.tick_time * slew_per_s;
      sys_ok[0] = it.press_1 >= thr_psi;
      sys_ok[1] = it.press_2 >= thr_psi;
      sys_ok[2] = it.press_3 >= thr_psi;
      for (int e = 0; e < 3 && e < NUM_ENGINES; e++) begin
        pitch_on = sys_ok[PITCH_HYD_A[e]] | sys_ok[PITCH_HYD_B[e]];
        yaw_on   = sys_ok[YAW_HYD_A[e]] | sys_ok[YAW_HYD_B[e]];
        pitch_now[e] = slew_axis(pitch_now[e], pitch_aim[e], pitch_on, prod, pitch_clamp);
        yaw_now[e]   = slew_axis(yaw_now[e], yaw_aim[e], yaw_on, prod, yaw_clamp);
      end
    end
    for (int e = 0; e < 3; e++) begin
      res[2*e]   = (e < NUM_ENGINES) ? pitch_now[e] : '0;
      res[2*e+1] = (e < NUM_ENGINES) ? yaw_now[e] : '0;
    end
    return res;
  endfunction

  function automatic gimbal_item_t make_command(int unsigned eng, int pt, int yt);
    gimbal_item_t it;
    it.opcode       = OP_CMD;
    it.engine       = eng[1:0];
    it.pitch_target = angle_t'(pt);
    it.yaw_target   = angle_t'(yt);
    it.press_1      = press_t'($urandom_range(4095));
    it.press_2      = press_t'($urandom_range(4095));
    it.press_3      = press_t'($urandom_range(4095));
    it.tick_time    = 10'($urandom_range(1023));
    return it;
  endfunction

  function automatic gimbal_item_t make_tick(int unsigned p1, int unsigned p2,
                                             int unsigned p3, int unsigned t);
    gimbal_item_t it;
    it.opcode       = OP_TICK;
    it.engine       = 2'($urandom_range(3));
    it.pitch_target = angle_t'($urandom_range(8191));
    it.yaw_target   = angle_t'($urandom_range(8191));
    it.press_1      = press_t'(p1);
    it.press_2      = press_t'(p2);
    it.press_3      = press_t'(p3);
    it.tick_time    = 10'(t);
    return it;
  endfunction

  // pressures cluster around the threshold and the rails
  function automatic int unsigned pick_pressure();
    int v;
    case ($urandom_range(2))
      0: v = int'($urandom_range(4095));
      1: v = int'(thr_psi) + int'($urandom_range(4)) - 2;
      default: v = $urandom_range(1) ? 4095 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  function automatic int pick_angle(int unsigned limit);
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom_range(8191)) - 4096;
      1: v = int'($urandom_range(2 * limit + 600)) - int'(limit) - 300;
      2: v = ($urandom_range(1) ? int'(limit) : -int'(limit)) + int'($urandom_range(4)) - 2;
      default: v = int'($urandom_range(64)) - 32;
    endcase
    if (v < -4096) v = -4096;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  function automatic int unsigned pick_tick_time();
    case ($urandom_range(3))
      0: return $urandom_range(63);
      1: return $urandom_range(1023);
      2: begin
        case ($urandom_range(3))
          0: return 0;
          1: return 1;
          2: return 1022;
          default: return 1023;
        endcase
      end
      default: return $urandom_range(255);
    endcase
  endfunction

  task automatic enqueue(gimbal_item_t it);
    pending_items.push_back(it);
    outstanding++;
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 3)
        enqueue(make_command($urandom_range(3), pick_angle(pitch_clamp), pick_angle(yaw_clamp)));
      else
        enqueue(make_tick(pick_pressure(), pick_pressure(), pick_pressure(), pick_tick_time()));
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    case (idx)
      REG_PRESS_THR: thr_psi     = value & 32'hFFF;
      REG_SLEW_RATE: slew_per_s  = value & 32'hFFFF;
      REG_PITCH_LIM: pitch_clamp = value & 32'hFFF;
      REG_YAW_LIM:   yaw_clamp   = value & 32'hFFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(int unsigned thr, int unsigned slew,
                                int unsigned pitch_lim, int unsigned yaw_lim);
    write_register(REG_PRESS_THR, thr);
    write_register(REG_SLEW_RATE, slew);
    write_register(REG_PITCH_LIM, pitch_lim);
    write_register(REG_YAW_LIM, yaw_lim);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // input driver and result-side back-pressure
  always @(negedge clk) begin : drive_proc
    logic         next_valid;
    logic         next_ready;
    gimbal_item_t it;
    next_valid = in_valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_valid || in_took) begin
      next_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_items.size() > 0) begin
        if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
          in_gap = $urandom_range(8);
        end else begin
          it = pending_items.pop_front();
          next_valid      = 1'b1;
          in_opcode       <= it.opcode;
          in_engine       <= it.engine;
          in_pitch_target <= it.pitch_target;
          in_yaw_target   <= it.yaw_target;
          in_press_1      <= it.press_1;
          in_press_2      <= it.press_2;
          in_press_3      <= it.press_3;
          in_tick_time    <= it.tick_time;
        end
      end
    end
    in_valid <= next_valid;

    if (out_gap > 0) begin
      out_gap--;
      next_ready = 1'b0;
    end else if (out_idle_pct > 0 && $urandom_range(99) < out_idle_pct) begin
      out_gap = $urandom_range(8);
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    out_ready <= next_ready;
  end

  // predict on each input transaction, check each result transaction
  always @(posedge clk) begin : watch_proc
    gimbal_item_t got;
    gimbal_set_t  seen;
    gimbal_set_t  want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        got.opcode       = in_opcode;
        got.engine       = in_engine;
        got.pitch_target = in_pitch_target;
        got.yaw_target   = in_yaw_target;
        got.press_1      = in_press_1;
        got.press_2      = in_press_2;
        got.press_3      = in_press_3;
        got.tick_time    = in_tick_time;
        expected_positions.push_back(advance_gimbals(got));
      end
      if (out_valid && out_ready) begin
        seen = {out_right_yaw, out_right_pitch, out_left_yaw, out_left_pitch,
                out_center_yaw, out_center_pitch};
        if (outstanding > 0) outstanding--;
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none actual %h", $time, seen);
          mismatch_count++;
        end else begin
          want = expected_positions.pop_front();
          for (int f = 0; f < 6; f++) begin
            if (seen[f] !== want[f]) begin
              $display("%0t: %s expected %0d actual %0d", $time, axis_name(f),
                       $signed(want[f]), $signed(seen[f]));
              mismatch_count++;
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin : limit_proc
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gimbal_slew_rate_limiter_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus_proc
    thr_psi     = THR_DEFAULT;
    slew_per_s  = SLEW_DEFAULT;
    pitch_clamp = PITCH_DEFAULT;
    yaw_clamp   = YAW_DEFAULT;
    for (int e = 0; e < 3; e++) begin
      pitch_now[e] = '0;
      yaw_now[e]   = '0;
      pitch_aim[e] = '0;
      yaw_aim[e]   = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme goals, ignored engine, single-system power, zero time
    in_idle_pct  = 20;
    out_idle_pct = 20;
    enqueue(make_command(0, 4095, -4096));
    enqueue(make_command(1, -4096, 4095));
    enqueue(make_command(2, 300, -300));
    enqueue(make_command(3, 1234, -1234));
    enqueue(make_tick(0, 0, 0, 1023));
    enqueue(make_tick(1500, 1499, 1499, 1023));
    enqueue(make_tick(1499, 1500, 1499, 512));
    enqueue(make_tick(1499, 1499, 4095, 0));
    enqueue(make_tick(4095, 4095, 4095, 1));
    enqueue(make_tick(4095, 4095, 4095, 1023));
    enqueue(make_tick(4095, 4095, 4095, 1023));
    enqueue(make_command(0, 0, 0));
    enqueue(make_tick(4095, 0, 0, 1023));
    enqueue(make_command(2, -4096, 4095));
    enqueue(make_tick(0, 0, 4095, 1023));
    enqueue(make_command(3, 4095, 4095));
    enqueue(make_tick(0, 4095, 0, 300));
    enqueue(make_command(1, 5, -5));
    enqueue(make_tick(4095, 4095, 4095, 1));
    enqueue(make_tick(4095, 4095, 4095, 1023));
    queue_random(PHASE_ITEMS);
    wait_drained();

    for (int p = 1; p < PHASE_COUNT; p++) begin
      case (p)
        1: apply_settings(0, 65535, 4095, 4095);
        2: apply_settings(4095, 0, 0, 0);
        3: apply_settings(2048, 1, 0, 4095);
        PHASE_COUNT - 1: apply_settings(THR_DEFAULT, SLEW_DEFAULT, PITCH_DEFAULT, YAW_DEFAULT);
        default: apply_settings($urandom_range(4095),
                                $urandom_range(1) ? $urandom_range(2047) : $urandom_range(65535),
                                $urandom_range(4095), $urandom_range(4095));
      endcase
      // every third phase and the last one run without gaps or stalls
      if (p == PHASE_COUNT - 1 || p % 3 == 0) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = $urandom_range(40, 10);
        out_idle_pct = $urandom_range(40, 10);
      end
      @(posedge clk);
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    if (expected_positions.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_positions.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("gimbal_slew_rate_limiter_tb: PASS");
    else
      $display("gimbal_slew_rate_limiter_tb: FAIL");
    $finish;
  end

endmodule

>>> gimbal_slew_rate_limiter.f
hdl/gsrl_pkg.sv
hdl/gimbal_slew_rate_limiter.sv
bench/gimbal_slew_rate_limiter_tb.sv
